@@ sv/co_sensor_heater_cycle_sequencer_core_assert.svh @@
// ----------------------------------------------------------------------------
// Heater cycle sequencer assertion macros
// Concurrent assertion helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CO_SENSOR_HEATER_CYCLE_SEQUENCER_CORE_ASSERT_SVH
`define CO_SENSOR_HEATER_CYCLE_SEQUENCER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/hsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Heater cycle sequencer package
// Shared types, phase codes, register indexes and scaling helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned MS_W       = 26;

	localparam logic [CFG_IDX_W-1:0] REG_START_WAIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PURGE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEAT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COOL       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COOL_DUTY  = 3'd4;

	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	localparam logic [7:0]      FULL_DUTY = 8'hFF;
	localparam logic [MS_W-1:0] MS_PER_S  = 26'd1000;

	localparam logic [MS_W-1:0] RST_WAIT_MS  = 26'd5000;
	localparam logic [MS_W-1:0] RST_PURGE_MS = 26'd500000;
	localparam logic [MS_W-1:0] RST_HEAT_MS  = 26'd60000;
	localparam logic [MS_W-1:0] RST_COOL_MS  = 26'd90000;
	localparam logic [7:0]      RST_COOL_DUTY = 8'd71;

	typedef enum logic [2:0] {
		PH_WAIT  = 3'd0,
		PH_PURGE = 3'd1,
		PH_HEAT  = 3'd2,
		PH_COOL  = 3'd3,
		PH_HOLD  = 3'd4
	} phase_t;

	typedef struct packed {
		logic        command;
		logic [31:0] now_ms;
		logic [9:0]  gas_sample;
		logic [9:0]  supply_sample;
	} item_t;

	typedef struct packed {
		logic [2:0] phase;
		logic       led_on;
		logic [7:0] heater_duty;
		logic [9:0] fetched_reading;
		logic       fetched_valid;
		logic [9:0] latest_gas;
		logic [9:0] latest_supply;
		logic       samples_valid;
	} result_t;

	typedef struct packed {
		logic            wait_load;
		logic [MS_W-1:0] wait_ms;
		logic [MS_W-1:0] purge_ms;
		logic [MS_W-1:0] heat_ms;
		logic [MS_W-1:0] cool_ms;
		logic [7:0]      cool_duty;
	} cfg_t;

	// Seconds to milliseconds; a constant multiply that fits in 26 bits.
	function automatic logic [MS_W-1:0] ms_of(input logic [CFG_DATA_W-1:0] sec);
		ms_of = MS_W'(sec) * MS_PER_S;
	endfunction

endpackage

@@ sv/hsc_cfg.sv @@
// ----------------------------------------------------------------------------
// Heater cycle sequencer configuration registers
// Holds the purge, heat and cool lengths, already scaled to milliseconds, and the cooling duty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsc_cfg
	import hsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	logic [MS_W-1:0] purge_ms_q;
	logic [MS_W-1:0] heat_ms_q;
	logic [MS_W-1:0] cool_ms_q;
	logic [7:0]      cool_duty_q;
	logic [MS_W-1:0] wdata_ms;

	assign wdata_ms = ms_of(cfg_wdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			purge_ms_q  <= RST_PURGE_MS;
			heat_ms_q   <= RST_HEAT_MS;
			cool_ms_q   <= RST_COOL_MS;
			cool_duty_q <= RST_COOL_DUTY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PURGE:     purge_ms_q  <= wdata_ms;
				REG_HEAT:      heat_ms_q   <= wdata_ms;
				REG_COOL:      cool_ms_q   <= wdata_ms;
				REG_COOL_DUTY: cool_duty_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// The start wait length only matters at the moment it is written.
	always_comb begin
		cfg.wait_load = cfg_we && (cfg_index == REG_START_WAIT);
		cfg.wait_ms   = wdata_ms;
		cfg.purge_ms  = purge_ms_q;
		cfg.heat_ms   = heat_ms_q;
		cfg.cool_ms   = cool_ms_q;
		cfg.cool_duty = cool_duty_q;
	end

endmodule

@@ sv/hsc_step.sv @@
// ----------------------------------------------------------------------------
// Heater cycle sequencer step logic
// Sequencer state and its registered update for one step or fetch beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsc_step
	import hsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	phase_t          phase_q, phase_d;
	logic [31:0]     last_change_q, last_change_d;
	logic [MS_W-1:0] phase_ms_q, phase_ms_d;
	logic [9:0]      latched_q, latched_d;
	logic            latched_valid_q, latched_valid_d;
	logic [9:0]      gas_q, gas_d;
	logic [9:0]      supply_q, supply_d;
	logic            have_q, have_d;
	logic            led_q, led_d;
	logic [7:0]      duty_q, duty_d;
	logic [31:0]     elapsed;
	logic            expired;
	logic [9:0]      fetch_reading;
	logic            fetch_valid;

	// Elapsed time wraps with the millisecond counter.
	assign elapsed = item.now_ms - last_change_q;
	assign expired = elapsed > {6'd0, phase_ms_q};

	always_comb begin
		phase_d         = phase_q;
		last_change_d   = last_change_q;
		phase_ms_d      = phase_ms_q;
		latched_d       = latched_q;
		latched_valid_d = latched_valid_q;
		gas_d           = gas_q;
		supply_d        = supply_q;
		have_d          = have_q;
		led_d           = led_q;
		duty_d          = duty_q;
		fetch_reading   = '0;
		fetch_valid     = 1'b0;

		if (en) begin
			if (item.command == CMD_STEP) begin
				gas_d    = item.gas_sample;
				supply_d = item.supply_sample;
				have_d   = 1'b1;
				if (expired) begin
					last_change_d = item.now_ms;
					phase_ms_d    = '0;
					unique case (phase_q)
						PH_WAIT: begin
							phase_d    = PH_PURGE;
							phase_ms_d = cfg.purge_ms;
							led_d      = 1'b1;
							duty_d     = FULL_DUTY;
						end
						PH_PURGE: begin
							phase_d    = PH_HEAT;
							phase_ms_d = cfg.heat_ms;
							led_d      = 1'b1;
							duty_d     = FULL_DUTY;
						end
						PH_HEAT: begin
							phase_d    = PH_COOL;
							phase_ms_d = cfg.cool_ms;
							led_d      = 1'b0;
							duty_d     = cfg.cool_duty;
						end
						PH_COOL: begin
							phase_d         = PH_HOLD;
							latched_d       = item.gas_sample;
							latched_valid_d = 1'b1;
						end
						default: ;
					endcase
				end
			end else begin
				fetch_reading   = latched_valid_q ? latched_q : 10'd0;
				fetch_valid     = latched_valid_q;
				latched_d       = '0;
				latched_valid_d = 1'b0;
				phase_d         = PH_PURGE;
			end
		end else if (cfg.wait_load && (phase_q == PH_WAIT)) begin
			phase_ms_d = cfg.wait_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_WAIT;
			last_change_q   <= '0;
			phase_ms_q      <= RST_WAIT_MS;
			latched_q       <= '0;
			latched_valid_q <= 1'b0;
			gas_q           <= '0;
			supply_q        <= '0;
			have_q          <= 1'b0;
			led_q           <= 1'b0;
			duty_q          <= '0;
		end else begin
			phase_q         <= phase_d;
			last_change_q   <= last_change_d;
			phase_ms_q      <= phase_ms_d;
			latched_q       <= latched_d;
			latched_valid_q <= latched_valid_d;
			gas_q           <= gas_d;
			supply_q        <= supply_d;
			have_q          <= have_d;
			led_q           <= led_d;
			duty_q          <= duty_d;
		end
	end

	always_comb begin
		result.phase           = phase_d;
		result.led_on          = led_d;
		result.heater_duty     = duty_d;
		result.fetched_reading = fetch_reading;
		result.fetched_valid   = fetch_valid;
		result.latest_gas      = gas_d;
		result.latest_supply   = supply_d;
		result.samples_valid   = have_d;
	end

endmodule

@@ sv/co_sensor_heater_cycle_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// Gas sensor heater cycle sequencer
// Steps the heater through wait, purge, heat, cool and hold, and latches
// the gas reading for a later fetch.
// Flow: an accepted item beat waits in the input stage until the result
// register is empty or draining; then result_q and result_valid are loaded.
// Throughput: one item per cycle unless result_ready stalls, set by the state
// update that compares elapsed milliseconds against the current phase length.
// Reset: arst_n clears the valid flags of both stages and the sequencer state
// and loads the default phase lengths and cooling duty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "co_sensor_heater_cycle_sequencer_core_assert.svh"

module co_sensor_heater_cycle_sequencer_core
	import hsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    fire;
	result_t step_result;
	result_t result_q;
	logic    result_valid_q;

	// The held beat moves on when the result register is empty or draining.
	assign fire       = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || fire;

	hsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hsc_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= step_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`HSC_ASSERT_NEXT(a_fire_gives_result, fire, result_valid_q, "processed beat produced no result")
	`HSC_ASSERT_NEXT(a_s1_held, valid_s1 && !fire, valid_s1, "stalled beat dropped from input stage")
	`HSC_ASSERT_SAME(a_fetch_forces_purge, result_valid_q && result_q.fetched_valid,
		result_q.phase == PH_PURGE, "fetch result not in purge phase")
	`HSC_ASSERT_SAME(a_led_full_duty, result_valid_q && result_q.led_on,
		result_q.heater_duty == FULL_DUTY, "LED on without full heater duty")

endmodule

@@ bench/co_sensor_heater_cycle_sequencer_core_checker.sv @@
// ----------------------------------------------------------------------------
// Heater cycle sequencer checker
// Watches the item, result and register ports, runs its own model of the
// phase sequencer on every accepted item beat and compares each result beat
// field by field against the oldest predicted status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module co_sensor_heater_cycle_sequencer_core_checker
	import hsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_ready,
	input  item_t                 item,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int unsigned           mismatches,
	output int unsigned           outstanding
);

	// Register copies.
	logic [15:0] wait_s;
	logic [15:0] purge_s;
	logic [15:0] heat_s;
	logic [15:0] cool_s;
	logic [7:0]  cool_duty_set;

	// Sequencer state.
	phase_t      cur_phase;
	logic [31:0] mark_ms;
	logic [15:0] span_s;
	logic [9:0]  held_reading;
	logic        held_valid;
	logic [9:0]  last_gas;
	logic [9:0]  last_supply;
	logic        seen_step;
	logic        led_state;
	logic [7:0]  duty_state;

	result_t status_due[$];

	task automatic note_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_START_WAIT: begin
				wait_s = val;
				if (cur_phase == PH_WAIT)
					span_s = val;
			end
			REG_PURGE:     purge_s = val;
			REG_HEAT:      heat_s = val;
			REG_COOL:      cool_s = val;
			REG_COOL_DUTY: cool_duty_set = val[7:0];
			default: ;
		endcase
	endtask

	task automatic advance_phase(input logic [31:0] now);
		mark_ms = now;
		span_s = '0;
		case (cur_phase)
			PH_WAIT: begin
				cur_phase = PH_PURGE;
				span_s = purge_s;
				led_state = 1'b1;
				duty_state = FULL_DUTY;
			end
			PH_PURGE: begin
				cur_phase = PH_HEAT;
				span_s = heat_s;
				led_state = 1'b1;
				duty_state = FULL_DUTY;
			end
			PH_HEAT: begin
				cur_phase = PH_COOL;
				span_s = cool_s;
				led_state = 1'b0;
				duty_state = cool_duty_set;
			end
			PH_COOL: begin
				cur_phase = PH_HOLD;
				held_reading = last_gas;
				held_valid = 1'b1;
			end
			default: ;
		endcase
	endtask

	task automatic sequence_item(input item_t it, output result_t st);
		logic [31:0] elapsed;
		logic [31:0] limit_ms;
		st = '0;
		if (it.command == CMD_STEP) begin
			last_gas = it.gas_sample;
			last_supply = it.supply_sample;
			seen_step = 1'b1;
			elapsed = it.now_ms - mark_ms;
			limit_ms = {16'b0, span_s} * 32'd1000;
			if (elapsed > limit_ms)
				advance_phase(it.now_ms);
		end else begin
			st.fetched_reading = held_valid ? held_reading : 10'd0;
			st.fetched_valid = held_valid;
			held_reading = '0;
			held_valid = 1'b0;
			cur_phase = PH_PURGE;
		end
		st.phase = cur_phase;
		st.led_on = led_state;
		st.heater_duty = duty_state;
		st.latest_gas = last_gas;
		st.latest_supply = last_supply;
		st.samples_valid = seen_step;
	endtask

	task automatic compare_status(input result_t got, input result_t want);
		if (got.phase !== want.phase)
			note_mismatch($sformatf("phase got %0d want %0d", got.phase, want.phase));
		if (got.led_on !== want.led_on)
			note_mismatch($sformatf("led_on got %b want %b", got.led_on, want.led_on));
		if (got.heater_duty !== want.heater_duty)
			note_mismatch($sformatf("heater_duty got %0d want %0d",
				got.heater_duty, want.heater_duty));
		if (got.fetched_reading !== want.fetched_reading)
			note_mismatch($sformatf("fetched_reading got %0d want %0d",
				got.fetched_reading, want.fetched_reading));
		if (got.fetched_valid !== want.fetched_valid)
			note_mismatch($sformatf("fetched_valid got %b want %b",
				got.fetched_valid, want.fetched_valid));
		if (got.latest_gas !== want.latest_gas)
			note_mismatch($sformatf("latest_gas got %0d want %0d",
				got.latest_gas, want.latest_gas));
		if (got.latest_supply !== want.latest_supply)
			note_mismatch($sformatf("latest_supply got %0d want %0d",
				got.latest_supply, want.latest_supply));
		if (got.samples_valid !== want.samples_valid)
			note_mismatch($sformatf("samples_valid got %b want %b",
				got.samples_valid, want.samples_valid));
	endtask

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		result_t st;
		if (!arst_n) begin
			wait_s = 16'd5;
			purge_s = 16'd500;
			heat_s = 16'd60;
			cool_s = 16'd90;
			cool_duty_set = RST_COOL_DUTY;
			cur_phase = PH_WAIT;
			mark_ms = '0;
			span_s = wait_s;
			held_reading = '0;
			held_valid = 1'b0;
			last_gas = '0;
			last_supply = '0;
			seen_step = 1'b0;
			led_state = 1'b0;
			duty_state = '0;
			status_due.delete();
		end else begin
			if (cfg_we)
				write_setting(cfg_index, cfg_wdata);
			// Check the result beat before queueing this edge's item beat.
			if (result_valid && result_ready) begin
				if (status_due.size() == 0)
					note_mismatch("result beat with no status pending");
				else
					compare_status(result, status_due.pop_front());
			end
			if (item_valid && item_ready) begin
				sequence_item(item, st);
				status_due.push_back(st);
			end
		end
		outstanding = status_due.size();
	end

endmodule

@@ bench/co_sensor_heater_cycle_sequencer_core_tb.sv @@
// ----------------------------------------------------------------------------
// Heater cycle sequencer testbench
// Drives directed and random step and fetch items through several register
// settings and idle patterns, with one long receiver hold-off; the checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module co_sensor_heater_cycle_sequencer_core_tb;
	import hsc_pkg::*;

	localparam int unsigned SEG_ITEMS   = 300;
	localparam int unsigned HOLD_CYCLES = 200;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	item_t                 item = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int unsigned mismatches;
	int unsigned outstanding;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_req = 0;
	int unsigned hold_done = 0;
	int unsigned hold_left = 0;
	logic [31:0] clock_ms = '0;

	co_sensor_heater_cycle_sequencer_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	co_sensor_heater_cycle_sequencer_core_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #2 clk = ~clk;

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			result_ready <= 1'b0;
			hold_left--;
		end else if (hold_req != hold_done) begin
			result_ready <= 1'b0;
			hold_left = HOLD_CYCLES - 1;
			hold_done++;
		end else begin
			result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#2_000_000;
		$display("co_sensor_heater_cycle_sequencer_core: mismatch");
		$finish;
	end

	function automatic item_t mk_item(input logic cmd, input logic [31:0] now,
			input logic [9:0] gas, input logic [9:0] supply);
		item_t it;
		it.command = cmd;
		it.now_ms = now;
		it.gas_sample = gas;
		it.supply_sample = supply;
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat.
	task automatic send_item(input item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering items and waits until every status has come back.
	task automatic settle();
		item_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
	endtask

	task automatic program_lengths(input logic [15:0] wait_len, input logic [15:0] purge_len,
			input logic [15:0] heat_len, input logic [15:0] cool_len,
			input logic [15:0] duty);
		write_reg(REG_START_WAIT, wait_len);
		write_reg(REG_PURGE, purge_len);
		write_reg(REG_HEAT, heat_len);
		write_reg(REG_COOL, cool_len);
		write_reg(REG_COOL_DUTY, duty);
		// Indexes past the last register must be ignored.
		for (int i = REG_COOL_DUTY + 1; i < (1 << CFG_IDX_W); i++)
			write_reg(CFG_IDX_W'(i), 16'($urandom));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_segment(input int unsigned count, input logic [31:0] span);
		item_t it;
		int unsigned pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			it.command = CMD_STEP;
			it.gas_sample = 10'($urandom);
			it.supply_sample = 10'($urandom);
			if (pick < 9) begin
				it.command = CMD_FETCH;
				it.now_ms = clock_ms + $urandom_range(0, 50);
			end else if (pick < 15) begin
				it.now_ms = $urandom;
			end else if (pick < 19) begin
				it.now_ms = clock_ms;
			end else begin
				it.now_ms = clock_ms + $urandom_range(0, span);
			end
			if (it.command == CMD_STEP)
				clock_ms = it.now_ms;
			send_item(it);
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Start wait with the reset lengths; the boundary itself must not advance.
		send_item(mk_item(CMD_STEP, 32'd0, 10'h000, 10'h000));
		send_item(mk_item(CMD_STEP, 32'd5000, 10'h3FF, 10'h3FF));
		settle();
		// Rewriting the wait length while waiting reloads the running phase.
		write_reg(REG_START_WAIT, 16'd2);
		cfg_we <= 1'b0;
		@(negedge clk);
		send_item(mk_item(CMD_STEP, 32'd2000, 10'h155, 10'h2AA));
		send_item(mk_item(CMD_STEP, 32'd2001, 10'h0F0, 10'h30F));
		// Fetch with nothing latched; its samples are not stored.
		send_item(mk_item(CMD_FETCH, 32'd2002, 10'h3FF, 10'h3FF));
		send_item(mk_item(CMD_STEP, 32'd502001, 10'h001, 10'h002));
		send_item(mk_item(CMD_STEP, 32'd502002, 10'h003, 10'h004));
		send_item(mk_item(CMD_STEP, 32'd562003, 10'h005, 10'h006));
		send_item(mk_item(CMD_STEP, 32'd652004, 10'h2AA, 10'h155));
		// In hold, a second step at the same time only stores its samples, a later one
		// also restarts the timer.
		send_item(mk_item(CMD_STEP, 32'd652004, 10'h011, 10'h022));
		send_item(mk_item(CMD_STEP, 32'd652005, 10'h033, 10'h044));
		send_item(mk_item(CMD_FETCH, 32'd652005, 10'h000, 10'h000));
		send_item(mk_item(CMD_FETCH, 32'd652005, 10'h3FF, 10'h000));
		// The forced phase has zero length, so one millisecond moves it on.
		send_item(mk_item(CMD_STEP, 32'd652006, 10'h100, 10'h200));
		send_item(mk_item(CMD_STEP, 32'hFFFF_FFFF, 10'h3FF, 10'h000));
		// Elapsed time across the wrap of the millisecond counter.
		send_item(mk_item(CMD_STEP, 32'h0000_0010, 10'h000, 10'h3FF));
		send_item(mk_item(CMD_STEP, 32'd90000, 10'h1FF, 10'h1FF));
		clock_ms = 32'd90000;

		send_idle_pct = 32;
		recv_idle_pct = 72;
		run_segment(SEG_ITEMS, 32'd300000);
		settle();
		program_lengths(16'd0, 16'd0, 16'd0, 16'd0, 16'h0000);
		run_segment(SEG_ITEMS, 32'd3);
		settle();

		send_idle_pct = 72;
		recv_idle_pct = 32;
		program_lengths(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
			16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), 16'($urandom));
		run_segment(SEG_ITEMS, 32'd3000);
		settle();
		program_lengths(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_segment(SEG_ITEMS, 32'hFFFF_FFFF);
		settle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		program_lengths(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
			16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)), 16'($urandom));
		// The receiver stops for a long stretch while items keep coming.
		hold_req++;
		run_segment(SEG_ITEMS, 32'd3000);
		settle();
		program_lengths(16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
			16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)), 16'($urandom));
		run_segment(SEG_ITEMS, 32'd5000);
		settle();

		repeat (10) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("co_sensor_heater_cycle_sequencer_core: match");
		else
			$display("co_sensor_heater_cycle_sequencer_core: mismatch");
		$finish;
	end

endmodule
